// ===== rtl/tps_pkg.sv =====
// Shared types and constants of the touch point sampler.
package tps_pkg;

  localparam int ADC_BITS_DEF    = 12;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int TH_W       = 12;
  localparam int COORD_W    = 16;
  localparam int ROUND_W    = 4;
  localparam int CMD_W      = 8;

  // Frame layout: command bits, one gap tick, result pairs, pad clocks, select high
  localparam int CMD_TICKS  = 2 * CMD_W;
  localparam int PAD_CLOCKS = 4;

  localparam logic [CMD_W-1:0] CMD_PRESSURE = 8'hb3;
  localparam logic [CMD_W-1:0] CMD_X        = 8'hd3;
  localparam logic [CMD_W-1:0] CMD_Y        = 8'h93;

  localparam int SCALE_MUL   = 4;
  localparam int SCALE_X_DIV = 59;
  localparam int SCALE_Y_DIV = 44;

  localparam logic [TH_W-1:0]    PRESS_TH_RST   = 12'd100;
  localparam logic [TH_W-1:0]    RELEASE_TH_RST = 12'd30;
  localparam logic [COORD_W-1:0] X_OFFSET_RST   = 16'd13;
  localparam logic [COORD_W-1:0] Y_BASE_RST     = 16'd260;
  localparam logic [ROUND_W-1:0] ROUNDS_RST     = 4'd6;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_TH   = 3'd0,
    CFG_RELEASE_TH = 3'd1,
    CFG_X_OFFSET   = 3'd2,
    CFG_Y_BASE     = 3'd3,
    CFG_ROUNDS     = 3'd4
  } tps_cfg_idx_e;

  typedef struct packed {
    logic [TH_W-1:0]    press_th;
    logic [TH_W-1:0]    release_th;
    logic [COORD_W-1:0] x_offset;
    logic [COORD_W-1:0] y_base;
    logic [ROUND_W-1:0] rounds;
  } tps_cfg_t;

  typedef enum logic [1:0] {
    KIND_TICK     = 2'd0,
    KIND_NO_TOUCH = 2'd1,
    KIND_AVERAGE  = 2'd2
  } tps_kind_e;

  // One classified tick, front to back
  typedef struct packed {
    logic               cs_n;
    logic               sclk;
    logic               mosi;
    tps_kind_e          kind;
    logic [COORD_W-1:0] sum_h;
    logic [COORD_W-1:0] sum_v;
    logic [ROUND_W-1:0] rounds;
  } tps_desc_t;

endpackage

// ===== rtl/tps_if.sv =====
// Valid/ready channel interfaces for tick items and result items.
interface tps_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic din;

  modport source (output valid, output start_req, output din, input ready);
  modport sink   (input valid, input start_req, input din, output ready);
endinterface

interface tps_out_if;
  logic                        valid;
  logic                        ready;
  logic                        cs_n;
  logic                        sclk;
  logic                        mosi;
  logic                        point_done;
  logic                        touched;
  logic [tps_pkg::COORD_W-1:0] x_pos;
  logic [tps_pkg::COORD_W-1:0] y_pos;

  modport source (output valid, output cs_n, output sclk, output mosi, output point_done,
                  output touched, output x_pos, output y_pos, input ready);
  modport sink   (input valid, input cs_n, input sclk, input mosi, input point_done,
                  input touched, input x_pos, input y_pos, output ready);
endinterface

// ===== rtl/tps_fifo.sv =====
// Small register queue between the sequencer front and the report back end.
module tps_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0]    wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o  = (cnt_q == CW'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign do_push = push_i & ~full_o;
  assign do_pop  = pop_i & ~empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (do_push) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (do_pop) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

// ===== rtl/tps_front.sv =====
// Tick sequencer: serial frame timing, round control, scaling and accumulation.
module tps_front #(
  parameter int ADC_BITS = tps_pkg::ADC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  tps_in_if.sink              in_ch,
  input  tps_pkg::tps_cfg_t   cfg_i,
  input  logic                full_i,
  output logic                push_o,
  output tps_pkg::tps_desc_t  desc_o
);

  localparam int RES_START = tps_pkg::CMD_TICKS + 1;
  localparam int RES_END   = RES_START + 2 * ADC_BITS;
  localparam int CS_TICK   = RES_END + 2 * tps_pkg::PAD_CLOCKS;
  localparam int TW        = $clog2(CS_TICK + 1);

  // Exact constant division: (4*r*M) >> SH with M = ceil(2^SH / d)
  localparam int NW = ADC_BITS + 2;
  localparam int SH = NW + 7;
  localparam int MW = SH - 4;
  localparam int PW = NW + MW;
  localparam logic [MW-1:0] MX =
    MW'((2 ** SH + tps_pkg::SCALE_X_DIV - 1) / tps_pkg::SCALE_X_DIV);
  localparam logic [MW-1:0] MY =
    MW'((2 ** SH + tps_pkg::SCALE_Y_DIV - 1) / tps_pkg::SCALE_Y_DIV);

  typedef enum logic [4:0] {
    PH_IDLE = 5'b00001,
    PH_Z1   = 5'b00010,
    PH_XR   = 5'b00100,
    PH_YR   = 5'b01000,
    PH_Z2   = 5'b10000
  } tps_phase_e;

  tps_phase_e                     phase_q, phase_d;
  logic [TW-1:0]                  t_q, t_d;
  logic [tps_pkg::CMD_W-1:0]      cmd_q, cmd_d;
  logic [ADC_BITS-1:0]            res_q, res_d;
  logic [tps_pkg::ROUND_W-1:0]    round_q, round_d, round_inc;
  logic [tps_pkg::COORD_W-1:0]    sum_h_q, sum_h_d, sum_v_q, sum_v_d;
  logic [tps_pkg::COORD_W-1:0]    sum_h_inc, sum_v_inc, res_wide;
  logic [tps_pkg::COORD_W-1:0]    scaled_x, scaled_y;
  logic [ADC_BITS-1:0]            raw_x_q, raw_x_d, raw_y_q, raw_y_d;
  logic [NW-1:0]                  nx, ny;
  logic [PW-1:0]                  prod_x_q, prod_y_q;
  logic                           accept;

  assign accept      = in_ch.valid & ~full_i;
  assign in_ch.ready = ~full_i;
  assign push_o      = accept;

  // Raw readings stay put for a whole frame, so these products settle long before use
  assign nx       = {raw_x_q, 2'b00};
  assign ny       = {raw_y_q, 2'b00};
  assign scaled_x = tps_pkg::COORD_W'(prod_x_q >> SH);
  assign scaled_y = tps_pkg::COORD_W'(prod_y_q >> SH);

  assign round_inc = round_q + 1'b1;
  assign sum_h_inc = sum_h_q + scaled_y;
  assign sum_v_inc = sum_v_q + scaled_x;
  assign res_wide  = tps_pkg::COORD_W'(res_q);

  always_comb begin
    phase_d = phase_q;
    t_d     = t_q;
    cmd_d   = cmd_q;
    res_d   = res_q;
    round_d = round_q;
    sum_h_d = sum_h_q;
    sum_v_d = sum_v_q;
    raw_x_d = raw_x_q;
    raw_y_d = raw_y_q;

    desc_o        = '0;
    desc_o.cs_n   = 1'b1;
    desc_o.kind   = tps_pkg::KIND_TICK;

    unique case (phase_q)
      PH_IDLE: begin
        if (in_ch.start_req) begin
          round_d = '0;
          sum_h_d = '0;
          sum_v_d = '0;
          if (cfg_i.rounds == '0) begin
            desc_o.kind = tps_pkg::KIND_NO_TOUCH;
          end else begin
            phase_d = PH_Z1;
            t_d     = '0;
            cmd_d   = tps_pkg::CMD_PRESSURE;
            res_d   = '0;
          end
        end
      end
      default: begin
        if (t_q < TW'(CS_TICK)) begin
          desc_o.cs_n = 1'b0;
          // every frame tick before select-high toggles on the tick parity
          desc_o.sclk = t_q[0];
          if (t_q < TW'(tps_pkg::CMD_TICKS)) begin
            desc_o.mosi = cmd_q[tps_pkg::CMD_W-1];
            if (t_q[0]) begin
              cmd_d = {cmd_q[tps_pkg::CMD_W-2:0], 1'b0};
            end
          end
          if (t_q >= TW'(RES_START) && t_q < TW'(RES_END) && !t_q[0]) begin
            res_d = {res_q[ADC_BITS-2:0], in_ch.din};
          end
          t_d = t_q + 1'b1;
        end else begin
          t_d   = '0;
          res_d = '0;
          unique case (phase_q)
            PH_Z1: begin
              if (res_wide > tps_pkg::COORD_W'(cfg_i.press_th)) begin
                phase_d = PH_XR;
                cmd_d   = tps_pkg::CMD_X;
              end else begin
                phase_d     = PH_IDLE;
                desc_o.kind = tps_pkg::KIND_NO_TOUCH;
              end
            end
            PH_XR: begin
              raw_x_d = res_q;
              phase_d = PH_YR;
              cmd_d   = tps_pkg::CMD_Y;
            end
            PH_YR: begin
              raw_y_d = res_q;
              phase_d = PH_Z2;
              cmd_d   = tps_pkg::CMD_PRESSURE;
            end
            default: begin
              if (res_wide > tps_pkg::COORD_W'(cfg_i.release_th)) begin
                sum_h_d = sum_h_inc;
                sum_v_d = sum_v_inc;
                round_d = round_inc;
                if (round_inc >= cfg_i.rounds) begin
                  phase_d       = PH_IDLE;
                  desc_o.kind   = tps_pkg::KIND_AVERAGE;
                  desc_o.sum_h  = sum_h_inc;
                  desc_o.sum_v  = sum_v_inc;
                  desc_o.rounds = round_inc;
                end else begin
                  phase_d = PH_Z1;
                  cmd_d   = tps_pkg::CMD_PRESSURE;
                end
              end else begin
                phase_d = PH_IDLE;
                // released before any round counted: no touch
                if (round_q == '0) begin
                  desc_o.kind = tps_pkg::KIND_NO_TOUCH;
                end else begin
                  desc_o.kind   = tps_pkg::KIND_AVERAGE;
                  desc_o.sum_h  = sum_h_q;
                  desc_o.sum_v  = sum_v_q;
                  desc_o.rounds = round_q;
                end
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      t_q     <= '0;
      cmd_q   <= '0;
      res_q   <= '0;
      round_q <= '0;
      sum_h_q <= '0;
      sum_v_q <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      t_q     <= t_d;
      cmd_q   <= cmd_d;
      res_q   <= res_d;
      round_q <= round_d;
      sum_h_q <= sum_h_d;
      sum_v_q <= sum_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      raw_x_q <= raw_x_d;
      raw_y_q <= raw_y_d;
    end
    prod_x_q <= {{MW{1'b0}}, nx} * {{NW{1'b0}}, MX};
    prod_y_q <= {{MW{1'b0}}, ny} * {{NW{1'b0}}, MY};
  end

endmodule

// ===== rtl/tps_back.sv =====
// Report back end: averaging divider, offset/base and the output register.
module tps_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               empty_i,
  input  tps_pkg::tps_desc_t desc_i,
  output logic               pop_o,
  input  tps_pkg::tps_cfg_t  cfg_i,
  tps_out_if.source          out_ch
);

  localparam int SW = tps_pkg::COORD_W;
  localparam int RW = tps_pkg::ROUND_W;
  localparam int CW = $clog2(SW);

  typedef enum logic [2:0] {
    BK_FETCH = 3'b001,
    BK_DIV   = 3'b010,
    BK_EMIT  = 3'b100
  } tps_back_e;

  tps_back_e      st_q, st_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic [RW-1:0]  dv_q, dv_d;
  logic [SW-1:0]  num_h_q, num_h_d, num_v_q, num_v_d;
  logic [RW-1:0]  rem_h_q, rem_h_d, rem_v_q, rem_v_d;
  logic [RW:0]    sh_h, sh_v;
  logic           ge_h, ge_v;

  logic           ov_q, ov_d, load;
  logic           o_cs_n_d, o_sclk_d, o_mosi_d, o_done_d, o_touch_d;
  logic [SW-1:0]  o_x_d, o_y_d;
  logic           slot_free;

  assign slot_free = ~ov_q | out_ch.ready;

  // restoring divide, one quotient bit per cycle in each lane
  assign sh_h = {rem_h_q, num_h_q[SW-1]};
  assign sh_v = {rem_v_q, num_v_q[SW-1]};
  assign ge_h = (sh_h >= {1'b0, dv_q});
  assign ge_v = (sh_v >= {1'b0, dv_q});

  always_comb begin
    st_d      = st_q;
    cnt_d     = cnt_q;
    dv_d      = dv_q;
    num_h_d   = num_h_q;
    num_v_d   = num_v_q;
    rem_h_d   = rem_h_q;
    rem_v_d   = rem_v_q;
    pop_o     = 1'b0;
    load      = 1'b0;
    o_cs_n_d  = 1'b1;
    o_sclk_d  = 1'b0;
    o_mosi_d  = 1'b0;
    o_done_d  = 1'b0;
    o_touch_d = 1'b0;
    o_x_d     = '0;
    o_y_d     = '0;

    unique case (st_q)
      BK_FETCH: begin
        if (!empty_i) begin
          if (desc_i.kind == tps_pkg::KIND_AVERAGE) begin
            pop_o   = 1'b1;
            num_h_d = desc_i.sum_h;
            num_v_d = desc_i.sum_v;
            dv_d    = desc_i.rounds;
            rem_h_d = '0;
            rem_v_d = '0;
            cnt_d   = '0;
            st_d    = BK_DIV;
          end else if (slot_free) begin
            pop_o    = 1'b1;
            load     = 1'b1;
            o_cs_n_d = desc_i.cs_n;
            o_sclk_d = desc_i.sclk;
            o_mosi_d = desc_i.mosi;
            case (desc_i.kind)
              tps_pkg::KIND_NO_TOUCH: o_done_d = 1'b1;
              default:                o_done_d = 1'b0;
            endcase
          end
        end
      end
      BK_DIV: begin
        rem_h_d = ge_h ? RW'(sh_h - {1'b0, dv_q}) : sh_h[RW-1:0];
        rem_v_d = ge_v ? RW'(sh_v - {1'b0, dv_q}) : sh_v[RW-1:0];
        num_h_d = {num_h_q[SW-2:0], ge_h};
        num_v_d = {num_v_q[SW-2:0], ge_v};
        cnt_d   = cnt_q + 1'b1;
        if (cnt_q == CW'(SW - 1)) begin
          st_d = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          o_done_d  = 1'b1;
          o_touch_d = 1'b1;
          o_x_d     = num_h_q - cfg_i.x_offset;
          o_y_d     = cfg_i.y_base - num_v_q;
          st_d      = BK_FETCH;
        end
      end
      default: st_d = BK_FETCH;
    endcase

    ov_d = load | (ov_q & ~out_ch.ready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= BK_FETCH;
      cnt_q <= '0;
      ov_q  <= 1'b0;
    end else begin
      st_q  <= st_d;
      cnt_q <= cnt_d;
      ov_q  <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dv_q    <= dv_d;
    num_h_q <= num_h_d;
    num_v_q <= num_v_d;
    rem_h_q <= rem_h_d;
    rem_v_q <= rem_v_d;
    if (load) begin
      out_ch.cs_n       <= o_cs_n_d;
      out_ch.sclk       <= o_sclk_d;
      out_ch.mosi       <= o_mosi_d;
      out_ch.point_done <= o_done_d;
      out_ch.touched    <= o_touch_d;
      out_ch.x_pos      <= o_x_d;
      out_ch.y_pos      <= o_y_d;
    end
  end

  assign out_ch.valid = ov_q;

endmodule

// ===== rtl/touch_point_sampler.sv =====
// Top level of the resistive touch point sampler.
//
//   channel   dir  handshake          payload
//   in_ch     in   valid/ready        start_req, din (one serial half-clock tick)
//   out_ch    out  valid/ready        cs_n, sclk, mosi, point_done, touched, x_pos, y_pos
//   cfg       in   cfg_we_i (no wait) cfg_idx_i, cfg_data_i
//
// One result item per tick item. Ticks are taken one per clock while the queue has room.
// A report with averages holds the back end while it takes the item, runs two 16-by-4-bit
// restoring dividers (one quotient bit per cycle) and loads the output register once it is
// free; every other tick passes from the queue straight into the output register.
// Reset sets the configuration registers to their default values and the sequencer idle.
// A stalled output fills the queue, and then in_ch.ready drops.
module touch_point_sampler #(
  parameter int ADC_BITS    = tps_pkg::ADC_BITS_DEF,
  parameter int QUEUE_DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_data_i,
  tps_in_if.sink                         in_ch,
  tps_out_if.source                      out_ch
);

  tps_pkg::tps_cfg_t  cfg_q;
  tps_pkg::tps_desc_t push_desc, pop_desc;
  logic               push, pop, full, empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.press_th   <= tps_pkg::PRESS_TH_RST;
      cfg_q.release_th <= tps_pkg::RELEASE_TH_RST;
      cfg_q.x_offset   <= tps_pkg::X_OFFSET_RST;
      cfg_q.y_base     <= tps_pkg::Y_BASE_RST;
      cfg_q.rounds     <= tps_pkg::ROUNDS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        tps_pkg::CFG_PRESS_TH:   cfg_q.press_th   <= cfg_data_i[tps_pkg::TH_W-1:0];
        tps_pkg::CFG_RELEASE_TH: cfg_q.release_th <= cfg_data_i[tps_pkg::TH_W-1:0];
        tps_pkg::CFG_X_OFFSET:   cfg_q.x_offset   <= cfg_data_i;
        tps_pkg::CFG_Y_BASE:     cfg_q.y_base     <= cfg_data_i;
        tps_pkg::CFG_ROUNDS:     cfg_q.rounds     <= cfg_data_i[tps_pkg::ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  tps_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch),
    .cfg_i  (cfg_q),
    .full_i (full),
    .push_o (push),
    .desc_o (push_desc)
  );

  tps_fifo #(
    .WIDTH ($bits(tps_pkg::tps_desc_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i (push_desc),
    .full_o  (full),
    .pop_i   (pop),
    .rdata_o (pop_desc),
    .empty_o (empty)
  );

  tps_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .desc_i  (pop_desc),
    .pop_o   (pop),
    .cfg_i   (cfg_q),
    .out_ch  (out_ch)
  );

endmodule

// ===== rtl/tps_checker.sv =====
// Port-level checks of the touch point sampler, bound to the top level.
module tps_checker #(
  parameter int QUEUE_DEPTH = tps_pkg::QUEUE_DEPTH_DEF
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        cs_n,
  input logic                        sclk,
  input logic                        mosi,
  input logic                        point_done,
  input logic                        touched,
  input logic [tps_pkg::COORD_W-1:0] x_pos,
  input logic [tps_pkg::COORD_W-1:0] y_pos
);

  // queue entries, the divider slot and the output register
  localparam int LIMIT = QUEUE_DEPTH + 2;
  localparam int OW    = $clog2(LIMIT + 1) + 1;

  logic          in_fire, out_fire;
  logic [OW-1:0] open_q;

  assign in_fire  = in_valid & in_ready;
  assign out_fire = out_valid & out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_fire && !out_fire) begin
      open_q <= open_q + 1'b1;
    end else if (out_fire && !in_fire) begin
      open_q <= open_q - 1'b1;
    end
  end

  a_no_extra_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (open_q != '0))
    else $error("result item without an outstanding tick item");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q <= OW'(LIMIT))
    else $error("more items in flight than the design can hold");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(point_done) && $stable(x_pos)
      && $stable(y_pos) && $stable(cs_n))
    else $error("stalled result item changed");

  a_report_on_select_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && point_done |-> cs_n && !sclk && !mosi)
    else $error("point reported while a frame drives the bus");

  a_no_touch_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !(point_done && touched) |-> (x_pos == '0) && (y_pos == '0))
    else $error("coordinates nonzero without a touch report");

endmodule

bind touch_point_sampler tps_checker #(
  .QUEUE_DEPTH (QUEUE_DEPTH)
) u_tps_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .cs_n       (out_ch.cs_n),
  .sclk       (out_ch.sclk),
  .mosi       (out_ch.mosi),
  .point_done (out_ch.point_done),
  .touched    (out_ch.touched),
  .x_pos      (out_ch.x_pos),
  .y_pos      (out_ch.y_pos)
);

// ===== verif/tb.sv =====
// Testbench of the touch point sampler: tick-by-tick prediction and result checking.
`timescale 1ns / 1ps

module tb;
  import tps_pkg::*;

  localparam int ADC_BITS     = ADC_BITS_DEF;
  localparam int RES_START    = CMD_TICKS + 1;
  localparam int RES_END      = RES_START + 2 * ADC_BITS;
  localparam int CS_TICK      = RES_END + 2 * PAD_CLOCKS;
  localparam int DRAIN_CYCLES = 24;
  localparam int CYCLE_LIMIT  = 400_000;
  localparam int MAX_REPORTS  = 10;

  typedef enum logic [2:0] {
    SAMP_IDLE,
    SAMP_PRESS,
    SAMP_HORIZ,
    SAMP_VERT,
    SAMP_RELEASE
  } samp_phase_e;

  typedef struct packed {
    logic               cs_n;
    logic               sclk;
    logic               mosi;
    logic               point_done;
    logic               touched;
    logic [COORD_W-1:0] x_pos;
    logic [COORD_W-1:0] y_pos;
  } tick_result_t;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  tps_in_if  in_ch();
  tps_out_if out_ch();

  touch_point_sampler #(.ADC_BITS(ADC_BITS)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_ch      (in_ch),
    .out_ch     (out_ch)
  );

  // Sampler prediction state
  tps_cfg_t              cfg_shadow;
  samp_phase_e           samp_phase    = SAMP_IDLE;
  int unsigned           frame_tick    = 0;
  logic [CMD_W-1:0]      cmd_bits      = '0;
  logic [ADC_BITS-1:0]   reading_bits  = '0;
  logic [ROUND_W-1:0]    rounds_done   = '0;
  logic [COORD_W-1:0]    sum_horiz     = '0;
  logic [COORD_W-1:0]    sum_vert      = '0;
  logic [COORD_W-1:0]    scaled_x      = '0;
  logic [COORD_W-1:0]    scaled_y      = '0;

  tick_result_t          expected_ticks[$];

  // Stimulus state
  logic [ADC_BITS-1:0]   reading_plan[$];
  logic [ADC_BITS-1:0]   frame_reading = '0;
  logic                  noisy_frame   = 1'b0;
  int                    send_idle_pct = 0;
  int                    stall_pct     = 0;

  int unsigned           items_sent     = 0;
  int unsigned           results_seen   = 0;
  int unsigned           point_count    = 0;
  int unsigned           touch_count    = 0;
  int unsigned           config_loads   = 0;
  int unsigned           mismatch_count = 0;
  int unsigned           cycle_count    = 0;

  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // ---------------------------------------------------------------- prediction

  function automatic void open_frame(input samp_phase_e ph, input logic [CMD_W-1:0] cmd);
    samp_phase   = ph;
    frame_tick   = 0;
    cmd_bits     = cmd;
    reading_bits = '0;
  endfunction

  // A stop with nothing accumulated reports no touch
  function automatic void post_point(inout tick_result_t res, input logic averaged);
    res.point_done = 1'b1;
    if (averaged && rounds_done != '0) begin
      res.touched = 1'b1;
      res.x_pos   = COORD_W'(sum_horiz / rounds_done) - cfg_shadow.x_offset;
      res.y_pos   = cfg_shadow.y_base - COORD_W'(sum_vert / rounds_done);
      touch_count++;
    end
    samp_phase = SAMP_IDLE;
    point_count++;
  endfunction

  task automatic predict_tick(input logic start, input logic bit_in);
    tick_result_t res;
    int unsigned  t;
    int unsigned  u;
    res      = '0;
    res.cs_n = 1'b1;
    if (samp_phase == SAMP_IDLE) begin
      if (start) begin
        rounds_done = '0;
        sum_horiz   = '0;
        sum_vert    = '0;
        scaled_x    = '0;
        scaled_y    = '0;
        if (cfg_shadow.rounds == '0) begin
          post_point(res, 1'b0);
        end else begin
          open_frame(SAMP_PRESS, CMD_PRESSURE);
        end
      end
    end else begin
      t = frame_tick;
      if (t < CMD_TICKS) begin
        res.cs_n = 1'b0;
        res.sclk = t[0];
        res.mosi = cmd_bits[CMD_W-1];
        if (t[0]) cmd_bits = cmd_bits << 1;
      end else if (t < RES_START) begin
        res.cs_n = 1'b0;
      end else if (t < RES_END) begin
        u        = t - RES_START;
        res.cs_n = 1'b0;
        res.sclk = !u[0];
        if (u[0]) reading_bits = {reading_bits[ADC_BITS-2:0], bit_in};
      end else if (t < CS_TICK) begin
        u        = t - RES_END;
        res.cs_n = 1'b0;
        res.sclk = !u[0];
      end
      if (t >= CS_TICK) begin
        case (samp_phase)
          SAMP_PRESS: begin
            if (reading_bits > cfg_shadow.press_th) begin
              open_frame(SAMP_HORIZ, CMD_X);
            end else begin
              post_point(res, 1'b0);
            end
          end
          SAMP_HORIZ: begin
            scaled_x = COORD_W'((reading_bits * SCALE_MUL) / SCALE_X_DIV);
            open_frame(SAMP_VERT, CMD_Y);
          end
          SAMP_VERT: begin
            scaled_y = COORD_W'((reading_bits * SCALE_MUL) / SCALE_Y_DIV);
            open_frame(SAMP_RELEASE, CMD_PRESSURE);
          end
          default: begin
            if (reading_bits > cfg_shadow.release_th) begin
              sum_horiz   = sum_horiz + scaled_y;
              sum_vert    = sum_vert + scaled_x;
              rounds_done = rounds_done + 1'b1;
              if (rounds_done >= cfg_shadow.rounds) begin
                post_point(res, 1'b1);
              end else begin
                open_frame(SAMP_PRESS, CMD_PRESSURE);
              end
            end else begin
              post_point(res, 1'b1);
            end
          end
        endcase
      end else begin
        frame_tick = t + 1;
      end
    end
    expected_ticks.push_back(res);
  endtask

  // ---------------------------------------------------------------- stimulus

  // Readings clustered at the threshold and the extremes, mostly above it
  function automatic logic [ADC_BITS-1:0] near_threshold(input logic [TH_W-1:0] th);
    case ($urandom_range(0, 9))
      0:       return th;
      1:       return (th == '1) ? th : th + 1'b1;
      2:       return '0;
      3:       return '1;
      4:       return ADC_BITS'($urandom_range(0, th));
      default: return (th == '1) ? th :
                      ADC_BITS'($urandom_range(th + 1, (1 << ADC_BITS) - 1));
    endcase
  endfunction

  // Converter data for the next tick, from the reading chosen for the current frame
  function automatic logic next_din();
    int unsigned u;
    if (samp_phase != SAMP_IDLE && frame_tick == 0) begin
      noisy_frame = 1'b0;
      if (reading_plan.size() != 0) begin
        frame_reading = reading_plan.pop_front();
      end else begin
        noisy_frame = ($urandom_range(0, 7) == 0);
        case (samp_phase)
          SAMP_PRESS:   frame_reading = near_threshold(cfg_shadow.press_th);
          SAMP_RELEASE: frame_reading = near_threshold(cfg_shadow.release_th);
          default: begin
            case ($urandom_range(0, 5))
              0:       frame_reading = '0;
              1:       frame_reading = '1;
              default: frame_reading = ADC_BITS'($urandom);
            endcase
          end
        endcase
      end
    end
    if (samp_phase == SAMP_IDLE || noisy_frame || frame_tick < RES_START ||
        frame_tick >= RES_END) begin
      return 1'($urandom_range(0, 1));
    end
    u = frame_tick - RES_START;
    if (!u[0]) return 1'($urandom_range(0, 1));
    return frame_reading[ADC_BITS - 1 - u / 2];
  endfunction

  task automatic send_tick(input logic start, input logic bit_in);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.start_req <= start;
    in_ch.din       <= bit_in;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    predict_tick(start, bit_in);
    items_sent++;
  endtask

  // One point: a few idle ticks, the start, then ticks until the point is reported.
  // Starts during the measurement must be ignored.
  task automatic measure_point();
    int unsigned lead;
    lead = $urandom_range(0, 2);
    repeat (lead) send_tick(1'b0, 1'($urandom_range(0, 1)));
    send_tick(1'b1, 1'($urandom_range(0, 1)));
    while (samp_phase != SAMP_IDLE) send_tick($urandom_range(0, 5) == 0, next_din());
  endtask

  task automatic plan_round(input logic [ADC_BITS-1:0] press, input logic [ADC_BITS-1:0] horiz,
                            input logic [ADC_BITS-1:0] vert, input logic [ADC_BITS-1:0] rel);
    reading_plan.push_back(press);
    reading_plan.push_back(horiz);
    reading_plan.push_back(vert);
    reading_plan.push_back(rel);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (expected_ticks.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_config(input tps_cfg_t c);
    wait_idle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_PRESS_TH;
    cfg_data_i <= CFG_DATA_W'(c.press_th);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_RELEASE_TH;
    cfg_data_i <= CFG_DATA_W'(c.release_th);
    @(posedge clk_i);
    cfg_idx_i  <= CFG_X_OFFSET;
    cfg_data_i <= c.x_offset;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_Y_BASE;
    cfg_data_i <= c.y_base;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_ROUNDS;
    cfg_data_i <= CFG_DATA_W'(c.rounds);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    cfg_shadow = c;
    config_loads++;
  endtask

  // ---------------------------------------------------------------- tests

  task automatic test_directed_points();
    int i;
    // pressure equal to the press threshold
    reading_plan.push_back(12'd100);
    measure_point();
    // release reading at its threshold in the first round: nothing accumulated
    plan_round(12'hfff, 12'hfff, 12'hfff, 12'd30);
    measure_point();
    // one round just above both thresholds then a release: average of one, both wrap
    plan_round(12'd101, 12'hfff, 12'h000, 12'd31);
    plan_round(12'hfff, 12'h000, 12'h000, 12'h000);
    measure_point();

    // zero rounds: the start tick reports at once
    load_config('{press_th: '0, release_th: '0, x_offset: '0, y_base: '0, rounds: '0});
    measure_point();
    measure_point();

    load_config('{press_th: '0, release_th: '0, x_offset: '1, y_base: '1, rounds: 4'd1});
    reading_plan.push_back(12'd0);
    measure_point();

    // thresholds at full scale can never be exceeded
    load_config('{press_th: '1, release_th: '1, x_offset: 16'd13, y_base: 16'd260,
                  rounds: 4'd15});
    reading_plan.push_back(12'hfff);
    measure_point();

    // three rounds of full-scale readings, stopping at the round count
    load_config('{press_th: '0, release_th: '0, x_offset: '0, y_base: '0, rounds: 4'd3});
    for (i = 0; i < 3; i++) begin
      plan_round(12'hfff, 12'hfff, 12'hfff, 12'hfff);
    end
    measure_point();
  endtask

  task automatic test_random_points(input int idle_pct, input int stall, input int flavor);
    int unsigned first_item;
    tps_cfg_t    c;
    case (flavor)
      0: c = '{press_th: TH_W'($urandom_range(0, 400)),
               release_th: TH_W'($urandom_range(0, 200)),
               x_offset: COORD_W'($urandom), y_base: COORD_W'($urandom),
               rounds: ROUND_W'($urandom_range(1, 4))};
      1: c = '{press_th: '0, release_th: '0, x_offset: '1, y_base: '0, rounds: 4'd15};
      2: c = '{press_th: TH_W'($urandom_range(0, 3000)),
               release_th: TH_W'($urandom_range(0, 3000)),
               x_offset: COORD_W'($urandom), y_base: COORD_W'($urandom),
               rounds: ROUND_W'($urandom_range(1, 15))};
      default: c = '{press_th: 12'hffe, release_th: 12'hffe, x_offset: '0, y_base: '1,
                     rounds: 4'd1};
    endcase
    load_config(c);
    send_idle_pct = idle_pct;
    stall_pct     = stall;
    first_item    = items_sent;
    while (items_sent - first_item < 150) begin
      measure_point();
    end
  endtask

  // ---------------------------------------------------------------- checking

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    tick_result_t got;
    tick_result_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{cs_n: out_ch.cs_n, sclk: out_ch.sclk, mosi: out_ch.mosi,
              point_done: out_ch.point_done, touched: out_ch.touched,
              x_pos: out_ch.x_pos, y_pos: out_ch.y_pos};
      if (expected_ticks.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("result %0d arrived with no tick outstanding", results_seen);
        end
      end else begin
        want = expected_ticks.pop_front();
        if (got.cs_n !== want.cs_n || got.sclk !== want.sclk || got.mosi !== want.mosi ||
            got.point_done !== want.point_done || got.touched !== want.touched ||
            got.x_pos !== want.x_pos || got.y_pos !== want.y_pos) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("result %0d: expected cs_n=%b sclk=%b mosi=%b done=%b touched=%b x=%0d y=%0d",
                     results_seen, want.cs_n, want.sclk, want.mosi, want.point_done,
                     want.touched, want.x_pos, want.y_pos);
            $display("  %0s got cs_n=%b sclk=%b mosi=%b done=%b touched=%b x=%0d y=%0d",
                     "", got.cs_n, got.sclk, got.mosi, got.point_done, got.touched,
                     got.x_pos, got.y_pos);
          end
        end
      end
      results_seen++;
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("timeout after %0d cycles, %0d ticks still outstanding", cycle_count,
             expected_ticks.size());
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst_ni          = 1'b0;
    cfg_we_i        = 1'b0;
    cfg_idx_i       = CFG_PRESS_TH;
    cfg_data_i      = '0;
    in_ch.valid     = 1'b0;
    in_ch.start_req = 1'b0;
    in_ch.din       = 1'b0;
    out_ch.ready    = 1'b0;
    cfg_shadow      = '{press_th: PRESS_TH_RST, release_th: RELEASE_TH_RST,
                        x_offset: X_OFFSET_RST, y_base: Y_BASE_RST, rounds: ROUNDS_RST};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_points();
    test_random_points(0, 0, 0);
    test_random_points(63, 0, 1);
    test_random_points(0, 63, 2);
    test_random_points(30, 30, 3);
    wait_idle();

    $display("Checked %0d ticks carrying %0d points (%0d touched) over %0d register settings",
             results_seen, point_count, touch_count, config_loads + 1);
    $display("Sender and receiver idling varied from none to 63 percent; %0d mismatches",
             mismatch_count);
    if (mismatch_count == 0 && expected_ticks.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tps_pkg.sv
rtl/tps_if.sv
rtl/tps_fifo.sv
rtl/tps_front.sv
rtl/tps_back.sv
rtl/touch_point_sampler.sv
rtl/tps_checker.sv
verif/tb.sv
